[design/rrlcg_pkg.sv]
// Shared types, constants and generator tables for the round-robin LCG random source.
// No dependencies.
package rrlcg_pkg;

    localparam int GEN_W     = 16;
    localparam int NUM_GEN   = 4;
    localparam int GIDX_W    = 2;
    localparam int X_W       = 36;
    localparam int VALUE_W   = 64;
    localparam int RANGE_W   = 32;
    localparam int BITCNT_W  = 7;
    localparam int REQ_W     = 2;
    localparam int CHUNK_W   = 3;
    localparam int MULC_W    = 17;
    localparam int ADDC_W    = 19;
    localparam int MODC_W    = 21;
    localparam int RCP_W     = 16;
    // reciprocals are floor(2^33/M); the top 32 bits of x carry 2^4 of that
    localparam int RCP_SH    = 29;

    localparam logic [VALUE_W-1:0] SEED_RESET = 64'h0001_0001_0001_0001;
    localparam logic [BITCNT_W-1:0] MAX_BITS  = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_RAW     = 2'd0,
        REQ_RANGE16 = 2'd1,
        REQ_RANGE32 = 2'd2
    } req_t;

    typedef struct packed {
        logic load;
        logic step_mul;
        logic step_quo;
        logic step_back;
        logic red_last;
        logic scale;
        logic out_load;
    } rrlcg_cmd_t;

    function automatic logic [MULC_W-1:0] gen_mul(input logic [GIDX_W-1:0] k);
        case (k)
            2'd0:    gen_mul = 17'd2416;
            2'd1:    gen_mul = 17'd84589;
            2'd2:    gen_mul = 17'd17221;
            default: gen_mul = 17'd7141;
        endcase
    endfunction

    function automatic logic [ADDC_W-1:0] gen_add(input logic [GIDX_W-1:0] k);
        case (k)
            2'd0:    gen_add = 19'd374441;
            2'd1:    gen_add = 19'd45989;
            2'd2:    gen_add = 19'd107839;
            default: gen_add = 19'd54773;
        endcase
    endfunction

    function automatic logic [MODC_W-1:0] gen_mod(input logic [GIDX_W-1:0] k);
        case (k)
            2'd0:    gen_mod = 21'd1771875;
            2'd1:    gen_mod = 21'd217728;
            2'd2:    gen_mod = 21'd510300;
            default: gen_mod = 21'd259200;
        endcase
    endfunction

    function automatic logic [RCP_W-1:0] gen_rcp(input logic [GIDX_W-1:0] k);
        case (k)
            2'd0:    gen_rcp = 16'd4847;
            2'd1:    gen_rcp = 16'd39452;
            2'd2:    gen_rcp = 16'd16833;
            default: gen_rcp = 16'd33140;
        endcase
    endfunction

    function automatic logic [BITCNT_W-1:0] clamp_bits(input logic [BITCNT_W-1:0] b);
        clamp_bits = (b > MAX_BITS) ? MAX_BITS : b;
    endfunction

endpackage

[design/rrlcg_ctrl.sv]
// Sequencer for the round-robin LCG random source: item handshake, chunk and
// remainder step counting, output valid. Depends on rrlcg_pkg.
module rrlcg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [6:0]            bit_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rrlcg_pkg::rrlcg_cmd_t cmd
);
    import rrlcg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_QUO,
        S_BACK,
        S_FIX,
        S_SCALE,
        S_FIN
    } state_t;

    state_t               state_reg;
    logic [CHUNK_W-1:0]   chunks_reg;
    logic                 scale_reg;
    logic                 out_valid_reg;

    logic                 accept;
    logic                 out_free;
    logic [BITCNT_W-1:0]  bc;
    logic [BITCNT_W-1:0]  bsum;
    logic [CHUNK_W-1:0]   n_chunks;
    logic                 n_scale;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        bc       = clamp_bits(bit_count);
        bsum     = bc + 7'd15;
        n_chunks = '0;
        n_scale  = 1'b0;
        case (req_t'(req_type))
            REQ_RAW:
            begin
                n_chunks = bsum[6:4];
            end
            REQ_RANGE16:
            begin
                n_chunks = 3'd1;
                n_scale  = 1'b1;
            end
            REQ_RANGE32:
            begin
                n_chunks = 3'd2;
                n_scale  = 1'b1;
            end
            default:
            begin
                n_chunks = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.step_mul  = (state_reg == S_MUL);
        cmd.step_quo  = (state_reg == S_QUO);
        cmd.step_back = (state_reg == S_BACK);
        cmd.red_last  = (state_reg == S_FIX);
        cmd.scale     = (state_reg == S_SCALE);
        cmd.out_load  = (state_reg == S_FIN) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chunks_reg    <= '0;
            scale_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        chunks_reg <= n_chunks;
                        scale_reg  <= n_scale;
                        state_reg  <= (n_chunks != '0) ? S_MUL : S_FIN;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_QUO;
                end
                S_QUO:
                begin
                    state_reg <= S_BACK;
                end
                S_BACK:
                begin
                    state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    chunks_reg <= chunks_reg - 3'd1;
                    if (chunks_reg == 3'd1)
                    begin
                        state_reg <= scale_reg ? S_SCALE : S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_SCALE:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("ready still high after item accepted");

    a_red_has_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUO || state_reg == S_BACK || state_reg == S_FIX)
        |-> (chunks_reg != '0))
        else $error("remainder step with no chunk pending");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && out_valid_reg && !out_ready |=> (state_reg == S_FIN))
        else $error("result dropped while output slot busy");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step_mul, cmd.step_quo, cmd.step_back, cmd.red_last,
                  cmd.scale, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

[design/rrlcg_dp.sv]
// Datapath for the round-robin LCG random source: generator state, shared
// multiplier, reciprocal remainder, chunk accumulator and output register. Depends on rrlcg_pkg.
module rrlcg_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  seed_wr_en,
    input  logic [63:0]           seed_wr_data,
    input  logic [1:0]            req_type,
    input  logic [6:0]            bit_count,
    input  logic [31:0]           range_low,
    input  logic [31:0]           range_high,
    input  rrlcg_pkg::rrlcg_cmd_t cmd,
    output logic [63:0]           value
);
    import rrlcg_pkg::*;

    logic [GEN_W-1:0]    gen_reg [NUM_GEN];
    logic [GIDX_W-1:0]   gidx_reg;

    logic [REQ_W-1:0]    mode_reg;
    logic [3:0]          shamt_reg;
    logic [RANGE_W-1:0]  lo_reg;
    logic [RANGE_W-1:0]  d_reg;
    logic [X_W-1:0]      x_reg;
    logic [GEN_W-1:0]    q_reg;
    logic [VALUE_W-1:0]  acc_reg;
    logic [VALUE_W-1:0]  prod_reg;
    logic [VALUE_W-1:0]  value_reg;

    logic [RANGE_W-1:0]  mul_a;
    logic [RANGE_W-1:0]  mul_b;
    logic [VALUE_W-1:0]  mul_p;
    logic [X_W-1:0]      mod_ext;
    logic [X_W-1:0]      x_fix;
    logic [BITCNT_W-1:0] bc;
    logic [BITCNT_W-1:0] bc_neg;
    logic [VALUE_W-1:0]  res;
    logic [GEN_W-1:0]    sum16;
    logic [RANGE_W-1:0]  sum32;

    assign value = value_reg;

    always_comb
    begin
        mul_a = {16'b0, gen_reg[gidx_reg]};
        mul_b = {15'b0, gen_mul(gidx_reg)};
        if (cmd.step_quo)
        begin
            mul_a = x_reg[X_W-1:X_W-RANGE_W];
            mul_b = {16'b0, gen_rcp(gidx_reg)};
        end
        else if (cmd.step_back)
        begin
            mul_a = {16'b0, q_reg};
            mul_b = {11'b0, gen_mod(gidx_reg)};
        end
        else if (cmd.scale)
        begin
            if (mode_reg == REQ_RANGE16)
            begin
                mul_a = {16'b0, d_reg[15:0]};
                mul_b = {16'b0, acc_reg[15:0]};
            end
            else
            begin
                mul_a = d_reg;
                mul_b = acc_reg[31:0];
            end
        end
        mul_p = mul_a * mul_b;
    end

    // quotient estimate is exact or one low, so one subtract finishes the remainder
    always_comb
    begin
        mod_ext = {15'b0, gen_mod(gidx_reg)};
        x_fix   = (x_reg >= mod_ext) ? x_reg - mod_ext : x_reg;
    end

    always_comb
    begin
        bc     = clamp_bits(bit_count);
        bc_neg = ~bc + 7'd1;
        sum16  = lo_reg[15:0] + prod_reg[31:16];
        sum32  = lo_reg + prod_reg[63:32];
        case (mode_reg)
            REQ_RAW:     res = acc_reg >> shamt_reg;
            REQ_RANGE16: res = {48'b0, sum16};
            REQ_RANGE32: res = {32'b0, sum32};
            default:     res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GEN; i++)
            begin
                gen_reg[i] <= SEED_RESET[GEN_W*i +: GEN_W];
            end
            gidx_reg <= '0;
        end
        else if (seed_wr_en)
        begin
            for (int i = 0; i < NUM_GEN; i++)
            begin
                gen_reg[i] <= seed_wr_data[GEN_W*i +: GEN_W];
            end
            gidx_reg <= '0;
        end
        else if (cmd.red_last)
        begin
            gen_reg[gidx_reg] <= x_fix[GEN_W-1:0];
            gidx_reg          <= gidx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= req_type;
            shamt_reg <= bc_neg[3:0];
            lo_reg    <= range_low;
            d_reg     <= range_high - range_low;
            acc_reg   <= '0;
        end
        if (cmd.step_mul)
        begin
            x_reg <= mul_p[X_W-1:0] + {17'b0, gen_add(gidx_reg)};
        end
        if (cmd.step_quo)
        begin
            q_reg <= mul_p[RCP_SH +: GEN_W];
        end
        if (cmd.step_back)
        begin
            x_reg <= x_reg - mul_p[X_W-1:0];
        end
        if (cmd.red_last)
        begin
            acc_reg <= {acc_reg[47:0], x_fix[GEN_W-1:0]};
        end
        if (cmd.scale)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.out_load)
        begin
            value_reg <= res;
        end
    end

endmodule

[design/round_robin_lcg_random_source_unit.sv]
// Top level of the round-robin LCG random source: controller plus datapath.
// Depends on rrlcg_pkg, rrlcg_ctrl, rrlcg_dp.
//
// Four 16-bit LCGs are stepped in turn; each step uses the shared multiplier for
// the product plus addend, a reciprocal quotient estimate and the back-multiply,
// then a correction step; a chunk passes S_MUL, S_QUO, S_BACK and S_FIX.
// An item is accepted in S_IDLE, then runs its n chunks, S_SCALE for range
// requests and S_FIN before the next can be accepted, n being the chunk count:
// raw requests need ceil(bit_count/16) chunks with bit_count clamped to 64,
// 16-bit range one chunk, 32-bit range two; zero bits or type 3 give 0. A held
// result does not block the next item until that item is finished. Writing the
// seed reloads all generators and restarts the round-robin at generator 0; write only while idle.
module round_robin_lcg_random_source_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [63:0] seed_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [6:0]  bit_count,
    input  logic [31:0] range_low,
    input  logic [31:0] range_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] value
);
    import rrlcg_pkg::*;

    rrlcg_cmd_t cmd;

    rrlcg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .bit_count (bit_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rrlcg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .req_type     (req_type),
        .bit_count    (bit_count),
        .range_low    (range_low),
        .range_high   (range_high),
        .cmd          (cmd),
        .value        (value)
    );

endmodule
